[rtl/core/timer_min_heap_scheduler_macros.svh]
// Assertion macros for the timer heap scheduler.
// Used by the top level; no other dependencies.
`ifndef TIMER_MIN_HEAP_SCHEDULER_MACROS_SVH
`define TIMER_MIN_HEAP_SCHEDULER_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error("%m");
`define ASSERT_NEXT(label, clk, rst, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error("%m");
`else
`define ASSERT_IMPLY(label, clk, rst, a, b)
`define ASSERT_NEXT(label, clk, rst, a, b)
`endif
`endif

[rtl/core/tmhs_pkg.sv]
// Types and constants for the timer heap scheduler.
// No dependencies.
`default_nettype none
package tmhs_pkg;
  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STOP = 2'd1;
  localparam logic [1:0] KIND_REARM = 2'd2;
  localparam logic [1:0] KIND_EXPIRE = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_FULL = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_ID_ZERO = 3'd3;
  localparam logic [2:0] ST_EXPIRED = 3'd4;

  localparam int MAX_POPS = 16;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] timer_id;
    logic [31:0] deadline;
    logic [31:0] period;
    logic [31:0] now_time;
  } req_t;

  typedef struct packed {
    logic [15:0] result_id;
    logic [2:0]  status;
    logic [4:0]  pending_count;
    logic        has_pending;
    logic [31:0] next_wait;
    logic        last;
  } rsp_t;

  // controller -> datapath
  typedef enum logic [3:0] {
    OP_NONE = 4'd0,
    OP_LOAD = 4'd1,   // latch request
    OP_INSERT = 4'd2, // write new entry at tail, start sift up
    OP_UP = 4'd3,     // one sift-up step
    OP_DOWN = 4'd4,   // one sift-down step
    OP_SEARCH = 4'd5, // one search step
    OP_REMOVE = 4'd6, // move tail into found slot
    OP_REARM = 4'd7,  // rewrite deadline at found slot
    OP_POP = 4'd8,    // move tail to root, keep popped entry
    OP_REINS = 4'd9,  // reinsert popped periodic entry
    OP_EMIT = 4'd10,  // form result
    OP_SRCH_INIT = 4'd11,
    OP_RESTART_UP = 4'd12
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] status;
    logic       use_pop_id;
    logic       last;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] kind;
    logic       full;
    logic       id_zero;
    logic       found;
    logic       search_done;
    logic       up_done;
    logic       down_done;
    logic       due;
    logic       pop_periodic;
    logic       empty;
  } sts_t;
endpackage
`default_nettype wire

[rtl/core/tmhs_datapath.sv]
// Heap storage, search and sift datapath for the timer heap scheduler.
// Depends on tmhs_pkg.
`default_nettype none
module tmhs_datapath
  import tmhs_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire req_t req_in,
  input  wire cmd_t cmd,
  output sts_t      sts,
  output rsp_t      rsp
);
  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic [31:0] heap_deadline [CAPACITY];
  logic [15:0] heap_ident [CAPACITY];
  logic [31:0] heap_period [CAPACITY];
  logic [CW-1:0] entry_count;
  logic [15:0] next_fresh_id;
  req_t req;
  logic [CW-1:0] pos;
  logic [15:0] pop_id;
  logic [31:0] pop_period;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  // sift-up view
  logic [CW-1:0] par;
  logic up_swap;
  assign par = (pos - CW'(1)) >> 1;
  assign up_swap = (pos != '0) &&
    (heap_deadline[pos[IW-1:0]] < heap_deadline[par[IW-1:0]]);

  // sift-down view
  logic [CW:0] lc, rc;
  logic [CW-1:0] m_a, m;
  always_comb begin
    lc = {pos, 1'b1};
    rc = {pos, 1'b0} + (CW+1)'(2);
    m_a = pos;
    if (lc < {1'b0, entry_count} &&
        heap_deadline[lc[IW-1:0]] < heap_deadline[pos[IW-1:0]]) m_a = lc[CW-1:0];
    m = m_a;
    if (rc < {1'b0, entry_count} &&
        heap_deadline[rc[IW-1:0]] < heap_deadline[m_a[IW-1:0]]) m = rc[CW-1:0];
  end

  logic [CW-1:0] tail;
  assign tail = entry_count - CW'(1);
  logic [15:0] ins_id;
  assign ins_id = (req.timer_id == '0) ? next_fresh_id : req.timer_id;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      next_fresh_id <= 16'd1;
    end else begin
      case (cmd.op)
        OP_LOAD: req <= req_in;
        OP_INSERT: begin
          heap_deadline[entry_count[IW-1:0]] <=
            (req.deadline == '0) ? req.now_time : req.deadline;
          heap_ident[entry_count[IW-1:0]] <= ins_id;
          heap_period[entry_count[IW-1:0]] <= req.period;
          req.timer_id <= ins_id;
          if (req.timer_id == '0)
            next_fresh_id <= (next_fresh_id == 16'hFFFF) ? 16'd1 : next_fresh_id + 16'd1;
          pos <= entry_count;
          entry_count <= entry_count + CW'(1);
        end
        OP_REINS: begin
          heap_deadline[entry_count[IW-1:0]] <= sat_add(req.now_time, pop_period);
          heap_ident[entry_count[IW-1:0]] <= pop_id;
          heap_period[entry_count[IW-1:0]] <= pop_period;
          pos <= entry_count;
          entry_count <= entry_count + CW'(1);
        end
        OP_UP: if (up_swap) begin
          heap_deadline[pos[IW-1:0]] <= heap_deadline[par[IW-1:0]];
          heap_ident[pos[IW-1:0]] <= heap_ident[par[IW-1:0]];
          heap_period[pos[IW-1:0]] <= heap_period[par[IW-1:0]];
          heap_deadline[par[IW-1:0]] <= heap_deadline[pos[IW-1:0]];
          heap_ident[par[IW-1:0]] <= heap_ident[pos[IW-1:0]];
          heap_period[par[IW-1:0]] <= heap_period[pos[IW-1:0]];
          pos <= par;
        end
        OP_DOWN: if (m != pos) begin
          heap_deadline[pos[IW-1:0]] <= heap_deadline[m[IW-1:0]];
          heap_ident[pos[IW-1:0]] <= heap_ident[m[IW-1:0]];
          heap_period[pos[IW-1:0]] <= heap_period[m[IW-1:0]];
          heap_deadline[m[IW-1:0]] <= heap_deadline[pos[IW-1:0]];
          heap_ident[m[IW-1:0]] <= heap_ident[pos[IW-1:0]];
          heap_period[m[IW-1:0]] <= heap_period[pos[IW-1:0]];
          pos <= m;
        end
        OP_SRCH_INIT: pos <= '0;
        OP_SEARCH: if (!sts.found) pos <= pos + CW'(1);
        OP_REMOVE: begin
          heap_deadline[pos[IW-1:0]] <= heap_deadline[tail[IW-1:0]];
          heap_ident[pos[IW-1:0]] <= heap_ident[tail[IW-1:0]];
          heap_period[pos[IW-1:0]] <= heap_period[tail[IW-1:0]];
          entry_count <= tail;
        end
        OP_REARM: heap_deadline[pos[IW-1:0]] <= sat_add(req.now_time, req.deadline);
        OP_POP: begin
          pop_id <= heap_ident[0];
          pop_period <= heap_period[0];
          heap_deadline[0] <= heap_deadline[tail[IW-1:0]];
          heap_ident[0] <= heap_ident[tail[IW-1:0]];
          heap_period[0] <= heap_period[tail[IW-1:0]];
          entry_count <= tail;
          pos <= '0;
        end
        OP_EMIT: begin
          rsp.result_id <= cmd.use_pop_id ? pop_id :
            ((cmd.status == ST_OK && req.kind == KIND_EXPIRE) ? 16'd0 : req.timer_id);
          rsp.status <= cmd.status;
          rsp.pending_count <= 5'(entry_count);
          rsp.has_pending <= entry_count != '0;
          rsp.next_wait <= (entry_count != '0 && heap_deadline[0] > req.now_time) ?
            heap_deadline[0] - req.now_time : 32'd0;
          rsp.last <= cmd.last;
        end
        default: ;
      endcase
      if (cmd.op == OP_RESTART_UP) pos <= pos;
    end
  end

  always_comb begin
    sts.kind = req.kind;
    sts.full = entry_count >= CW'(CAPACITY);
    sts.id_zero = req.timer_id == '0;
    sts.search_done = pos >= entry_count;
    sts.found = (pos < entry_count) && (heap_ident[pos[IW-1:0]] == req.timer_id);
    sts.up_done = !up_swap;
    sts.down_done = m == pos;
    sts.empty = entry_count == '0;
    sts.due = (entry_count != '0) && (heap_deadline[0] <= req.now_time);
    sts.pop_periodic = (pop_period != '0) && (entry_count < CW'(CAPACITY));
  end
endmodule
`default_nettype wire

[rtl/core/tmhs_control.sv]
// Command sequencer for the timer heap scheduler.
// Depends on tmhs_pkg.
`default_nettype none
module tmhs_control
  import tmhs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire logic out_busy,
  input  wire sts_t sts,
  output cmd_t      cmd
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_DEC    = 11'b00000000010,
    S_UP     = 11'b00000000100,
    S_SEARCH = 11'b00000001000,
    S_REMOVE = 11'b00000010000,
    S_DOWN   = 11'b00000100000,
    S_UP2    = 11'b00001000000,
    S_REARM  = 11'b00010000000,
    S_POPCHK = 11'b00100000000,
    S_POPDN  = 11'b01000000000,
    S_OUT    = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [2:0] status, status_next;
  logic use_pop, use_pop_next;
  logic [4:0] pops, pops_next;
  logic after_out, after_out_next; // 1: return to pop check after output
  logic up_then_down, up_then_down_next;
  logic emit_pending_next;

  always_comb begin
    state_next = state;
    status_next = status;
    use_pop_next = use_pop;
    pops_next = pops;
    after_out_next = after_out;
    up_then_down_next = up_then_down;
    emit_pending_next = 1'b0;
    cmd = '{op: OP_NONE, status: status, use_pop_id: use_pop, last: 1'b0};
    in_stall = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op = OP_LOAD;
          state_next = S_DEC;
          pops_next = '0;
          use_pop_next = 1'b0;
          after_out_next = 1'b0;
        end
      end
      S_DEC: begin
        case (sts.kind)
          KIND_START: if (sts.full) begin
            status_next = ST_FULL;
            emit_pending_next = 1'b1;
          end else begin
            status_next = ST_OK;
            cmd.op = OP_INSERT;
            up_then_down_next = 1'b0;
            state_next = S_UP;
          end
          KIND_STOP, KIND_REARM: if (sts.id_zero) begin
            status_next = ST_ID_ZERO;
            emit_pending_next = 1'b1;
          end else begin
            cmd.op = OP_SRCH_INIT;
            state_next = S_SEARCH;
          end
          default: state_next = S_POPCHK;
        endcase
      end
      S_SEARCH: begin
        cmd.op = OP_SEARCH;
        if (sts.found) begin
          status_next = ST_OK;
          state_next = (sts.kind == KIND_STOP) ? S_REMOVE : S_REARM;
        end else if (sts.search_done) begin
          status_next = ST_NOT_FOUND;
          emit_pending_next = 1'b1;
        end
      end
      S_REMOVE: begin
        cmd.op = OP_REMOVE;
        up_then_down_next = 1'b0;
        state_next = S_DOWN;
      end
      S_REARM: begin
        cmd.op = OP_REARM;
        up_then_down_next = 1'b1;
        state_next = S_UP;
      end
      S_UP: begin
        cmd.op = OP_UP;
        if (sts.up_done) begin
          if (up_then_down) state_next = S_DOWN;
          else emit_pending_next = 1'b1;
        end
      end
      S_DOWN: begin
        cmd.op = OP_DOWN;
        if (sts.down_done) begin
          if (sts.kind == KIND_STOP) begin
            state_next = S_UP2;
          end else if (sts.kind == KIND_EXPIRE) begin
            state_next = S_POPDN;
          end else emit_pending_next = 1'b1;
        end
      end
      S_UP2: begin
        cmd.op = OP_UP;
        if (sts.up_done) emit_pending_next = 1'b1;
      end
      S_POPCHK: begin
        if (pops != 5'(MAX_POPS) && sts.due) begin
          cmd.op = OP_POP;
          pops_next = pops + 5'd1;
          use_pop_next = 1'b1;
          status_next = ST_EXPIRED;
          state_next = S_DOWN;
        end else if (pops == '0) begin
          status_next = ST_OK;
          use_pop_next = 1'b0;
          after_out_next = 1'b0;
          emit_pending_next = 1'b1;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_POPDN: begin
        if (sts.pop_periodic) begin
          cmd.op = OP_REINS;
          up_then_down_next = 1'b0;
          after_out_next = 1'b1;
          state_next = S_UP;
        end else begin
          after_out_next = 1'b1;
          emit_pending_next = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_busy) begin
          cmd.op = OP_EMIT;
          // last unless another pop follows on the same heap state
          cmd.last = !after_out || (pops == 5'(MAX_POPS)) || !sts.due;
          state_next = after_out ? S_POPCHK : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
    if (emit_pending_next) state_next = S_OUT;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      status <= ST_OK;
      use_pop <= 1'b0;
      pops <= '0;
      after_out <= 1'b0;
      up_then_down <= 1'b0;
    end else begin
      state <= state_next;
      status <= status_next;
      use_pop <= use_pop_next;
      pops <= pops_next;
      after_out <= after_out_next;
      up_then_down <= up_then_down_next;
    end
  end
endmodule
`default_nettype wire

[rtl/core/tmhs_outbuf.sv]
// Result register for the timer heap scheduler: holds one result until taken.
// Depends on tmhs_pkg.
`default_nettype none
module tmhs_outbuf
  import tmhs_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire rsp_t in_rsp,
  output logic      out_valid,
  input  wire logic out_stall,
  output rsp_t      out_rsp
);
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (in_valid) out_valid <= 1'b1;
    else if (!out_stall) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_valid) out_rsp <= in_rsp;
  end
endmodule
`default_nettype wire

[rtl/core/timer_min_heap_scheduler.sv]
// Timer min-heap scheduler, top level: controller, heap datapath, result register.
// Depends on tmhs_pkg, tmhs_datapath, tmhs_control, tmhs_outbuf and timer_min_heap_scheduler_macros.svh.
// Start inserts at the tail and sifts up; stop/rearm first search the heap entry by entry,
// then do two sifts. Expire pops due entries, with one result per pop.
// One request at a time; the next is accepted once the controller is back in idle.
// Reset: synchronous; empties the heap and sets the fresh id counter to one.
`default_nettype none
`include "timer_min_heap_scheduler_macros.svh"
module timer_min_heap_scheduler
  import tmhs_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output rsp_t      out_data
);
  cmd_t cmd;
  sts_t sts;
  rsp_t rsp;
  logic emit_q;
  logic ob_busy;

  tmhs_datapath #(.CAPACITY(CAPACITY)) u_dp (
    .clk, .rst, .req_in(in_data), .cmd, .sts, .rsp
  );

  tmhs_control u_ctl (
    .clk, .rst, .in_valid, .in_stall, .out_busy(ob_busy), .sts, .cmd
  );

  always_ff @(posedge clk) begin
    if (rst) emit_q <= 1'b0;
    else emit_q <= cmd.op == OP_EMIT;
  end

  assign ob_busy = out_valid || emit_q;

  tmhs_outbuf u_ob (
    .clk, .rst, .in_valid(emit_q), .in_rsp(rsp),
    .out_valid, .out_stall, .out_rsp(out_data)
  );

  `ASSERT_IMPLY(a_emit_free, clk, rst, cmd.op == OP_EMIT, !emit_q && !out_valid)
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
endmodule
`default_nettype wire
